>>> hw/rtl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants for the chunked body decoder
// Phase and result codes, size-line character helpers, result FIFO sizing.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned SIZE_W    = 31;
  localparam int unsigned COUNT_W   = 33;
  localparam int unsigned SKIP_W    = 2;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_W-1:0] MAX_BODY_RST = 32'd1048576;

  localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_VT  = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF  = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BODY_LENGTH = 1'b0,
    CFG_MAX_BODY    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] body_length;
    logic [CFG_W-1:0] max_body;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_TAIL,
    PH_DATA,
    PH_SKIP,
    PH_OVF,
    PH_DONE
  } phase_t;

  // malformed maps to status 400, too large to status 413
  typedef enum logic [1:0] {
    KIND_PAYLOAD,
    KIND_FINISHED,
    KIND_MALFORMED,
    KIND_TOOLARGE
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] payload;
  } result_t;

  // up to two results per byte; v1 only ever set together with v0
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } result_pair_t;

  function automatic logic is_hex(input logic [BYTE_W-1:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
    end
    hex_value = t[3:0];
  endfunction

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    is_blank = (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF);
  endfunction

endpackage

>>> hw/rtl/cbd_if.sv
// ----------------------------------------------------------------------------
// cbd_if: valid/ready channels of the chunked body decoder
// Raw body byte channel and decoded result channel.
// ----------------------------------------------------------------------------
interface cbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface cbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload;

  modport source (output valid, output kind, output payload, input ready);
  modport sink   (input valid, input kind, input payload, output ready);
endinterface

>>> hw/rtl/cbd_parser.sv
// ----------------------------------------------------------------------------
// cbd_parser: body decode state machine
// Takes one registered byte per cycle, updates the framing state and
// produces up to two results for it.
// ----------------------------------------------------------------------------
module cbd_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cbd_pkg::cfg_t               cfg,
  input  logic                        step_valid,
  input  logic [cbd_pkg::BYTE_W-1:0]  step_byte,
  output cbd_pkg::result_pair_t       res
);
  import cbd_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [SIZE_W-1:0]   chunk_left_r, chunk_left_nxt;
  logic [SIZE_W-1:0]   size_accum_r, size_accum_nxt;
  logic                digit_seen_r, digit_seen_nxt;
  logic                cr_seen_r, cr_seen_nxt;
  logic [SKIP_W-1:0]   skip_left_r, skip_left_nxt;
  logic [COUNT_W-1:0]  byte_count_r, byte_count_nxt;

  logic                fixed_mode;
  logic [COUNT_W-1:0]  count_inc;
  logic                fixed_full;
  logic                fixed_last;
  logic                over_max;
  logic [SIZE_W-1:0]   chunk_dec;
  logic [SKIP_W-1:0]   skip_dec;
  logic                line_end;
  logic                digit;
  logic                accum_ovf;

  assign fixed_mode = (cfg.body_length != '0);
  assign count_inc  = byte_count_r + COUNT_W'(1);
  assign fixed_full = (byte_count_r >= {1'b0, cfg.body_length});
  assign fixed_last = (count_inc == {1'b0, cfg.body_length});
  // count + 1 > max  <=>  count >= max
  assign over_max   = (byte_count_r >= {1'b0, cfg.max_body});
  assign chunk_dec  = chunk_left_r - SIZE_W'(chunk_left_r != '0);
  assign skip_dec   = skip_left_r - SKIP_W'(skip_left_r != '0);
  assign line_end   = (step_byte == CH_LF) && cr_seen_r;
  assign digit      = is_hex(step_byte);
  // shifting in another digit would pass 0x7FFFFFFF
  assign accum_ovf  = (size_accum_r[SIZE_W-1:SIZE_W-4] != 4'h0);

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    chunk_left_nxt = chunk_left_r;
    size_accum_nxt = size_accum_r;
    digit_seen_nxt = digit_seen_r;
    cr_seen_nxt    = cr_seen_r;
    skip_left_nxt  = skip_left_r;
    byte_count_nxt = byte_count_r;
    if (step_valid && (phase_r != PH_DONE) && (phase_r <= PH_DONE)) begin
      if (fixed_mode) begin
        if (fixed_full) begin
          phase_nxt = PH_DONE;
        end else begin
          byte_count_nxt = count_inc;
          if (fixed_last) phase_nxt = PH_DONE;
        end
      end else begin
        unique case (phase_r) inside
          PH_DATA: begin
            if (over_max) begin
              phase_nxt = PH_DONE;
            end else begin
              byte_count_nxt = count_inc;
              chunk_left_nxt = chunk_dec;
              if (chunk_dec == '0) begin
                phase_nxt     = PH_SKIP;
                skip_left_nxt = SKIP_W'(2);
              end
            end
          end
          PH_SKIP: begin
            skip_left_nxt = skip_dec;
            if (skip_dec == '0) begin
              phase_nxt      = PH_SIZE;
              size_accum_nxt = '0;
              digit_seen_nxt = 1'b0;
              cr_seen_nxt    = 1'b0;
            end
          end
          PH_SIZE, PH_TAIL, PH_OVF: begin
            if (line_end) begin
              cr_seen_nxt = 1'b0;
              if ((phase_r == PH_OVF) || !digit_seen_r || (size_accum_r == '0)) begin
                phase_nxt = PH_DONE;
              end else begin
                chunk_left_nxt = size_accum_r;
                phase_nxt      = PH_DATA;
              end
            end else begin
              cr_seen_nxt = (step_byte == CH_CR);
              if (phase_r == PH_SIZE) begin
                if (digit) begin
                  if (accum_ovf) begin
                    phase_nxt = PH_OVF;
                  end else begin
                    size_accum_nxt = {size_accum_r[SIZE_W-5:0], hex_value(step_byte)};
                    digit_seen_nxt = 1'b1;
                  end
                end else if (digit_seen_r || !is_blank(step_byte)) begin
                  phase_nxt = PH_TAIL;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // results
  always_comb begin
    res = '0;
    res.r0.kind = KIND_PAYLOAD;
    res.r1.kind = KIND_FINISHED;
    if (step_valid && (phase_r != PH_DONE) && (phase_r <= PH_DONE)) begin
      if (fixed_mode) begin
        res.v0 = 1'b1;
        if (fixed_full) begin
          res.r0.kind = KIND_FINISHED;
        end else begin
          res.r0.payload = step_byte;
          res.v1         = fixed_last;
        end
      end else begin
        unique case (phase_r) inside
          PH_DATA: begin
            res.v0 = 1'b1;
            if (over_max) begin
              res.r0.kind = KIND_TOOLARGE;
            end else begin
              res.r0.payload = step_byte;
            end
          end
          PH_SIZE, PH_TAIL, PH_OVF: begin
            if (line_end) begin
              if ((phase_r == PH_OVF) || !digit_seen_r) begin
                res.v0      = 1'b1;
                res.r0.kind = KIND_MALFORMED;
              end else if (size_accum_r == '0) begin
                res.v0      = 1'b1;
                res.r0.kind = KIND_FINISHED;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SIZE;
      chunk_left_r <= '0;
      size_accum_r <= '0;
      digit_seen_r <= 1'b0;
      cr_seen_r    <= 1'b0;
      skip_left_r  <= '0;
      byte_count_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      chunk_left_r <= chunk_left_nxt;
      size_accum_r <= size_accum_nxt;
      digit_seen_r <= digit_seen_nxt;
      cr_seen_r    <= cr_seen_nxt;
      skip_left_r  <= skip_left_nxt;
      byte_count_r <= byte_count_nxt;
    end
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("decoder left the done phase");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |-> !res.v0 && !res.v1)
    else $error("result produced after done");

  a_second_is_finish: assert property (@(posedge clk) disable iff (!rst_n)
    res.v1 |-> res.v0 && res.r0.kind == KIND_PAYLOAD && phase_nxt == PH_DONE)
    else $error("second result not a final finish");

endmodule

>>> hw/rtl/cbd_result_fifo.sv
// ----------------------------------------------------------------------------
// cbd_result_fifo: result queue
// Takes up to two results per cycle and presents one per transaction.
// ----------------------------------------------------------------------------
module cbd_result_fifo (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cbd_pkg::result_pair_t            push,
  output logic [cbd_pkg::FIFO_CNT_W-1:0]   count,
  cbd_out_if.source                        out_ch
);
  import cbd_pkg::*;

  result_t                mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]  count_r, count_nxt;
  logic [1:0]             push_n;
  logic                   pop;
  logic [FIFO_PTR_W-1:0]  wr_ptr_p1;

  assign push_n    = {1'b0, push.v0} + {1'b0, push.v1};
  assign pop       = out_ch.valid && out_ch.ready;
  assign wr_ptr_p1 = wr_ptr_r + FIFO_PTR_W'(1);

  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
  assign count_nxt  = count_r + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);

  assign count          = count_r;
  assign out_ch.valid   = (count_r != '0);
  assign out_ch.kind    = mem_r[rd_ptr_r].kind;
  assign out_ch.payload = mem_r[rd_ptr_r].payload;

  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wr_ptr_r] <= push.r0;
    if (push.v1) mem_r[wr_ptr_p1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} + {{(FIFO_CNT_W-1){1'b0}}, push_n} <= (FIFO_CNT_W+1)'(FIFO_DEPTH) +
      {{FIFO_CNT_W{1'b0}}, pop})
    else $error("result queue overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0 && count_r != FIFO_CNT_W'(FIFO_DEPTH)) |->
      FIFO_PTR_W'(wr_ptr_r - rd_ptr_r) == count_r[FIFO_PTR_W-1:0])
    else $error("queue pointers disagree with count");

  a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 && !push.v0) |=> !out_ch.valid)
    else $error("result shown from an empty queue");

endmodule

>>> hw/rtl/chunked_body_decoder_top.sv
// ----------------------------------------------------------------------------
// chunked_body_decoder_top: HTTP message body decoder
// Fixed-length pass-through or chunked transfer decoding, one byte a cycle while in_ch.ready is high.
// ----------------------------------------------------------------------------
// Takes one body byte per cycle and sustains that rate with out_ch.ready held
// high: a byte is registered, decoded combinationally by the framing state
// machine and its results are registered into an 8-entry result queue whose
// head drives out_ch. The queue's single read port delivers one result per
// cycle while out_ch.ready is high; the last byte of a fixed-length body
// gives a payload byte and a finished result, which the queue absorbs. in_ch
// drops ready only when the queue lacks room for two more results behind the
// byte in decode. After a finished, malformed or too-large result all further
// bytes are taken and dropped until reset. Write body_length and max_body
// through the cfg port only while the decoder is idle.
module chunked_body_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbd_pkg::CFG_W-1:0]      cfg_wdata,
  cbd_in_if.sink                         in_ch,
  cbd_out_if.source                      out_ch
);
  import cbd_pkg::*;

  cfg_t                   cfg_r;
  logic                   in_valid_r;
  logic [BYTE_W-1:0]      in_byte_r;
  logic [FIFO_CNT_W-1:0]  fifo_count;
  logic [FIFO_CNT_W:0]    fifo_need;
  result_pair_t           res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.body_length <= '0;
      cfg_r.max_body    <= MAX_BODY_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BODY_LENGTH: cfg_r.body_length <= cfg_wdata;
        CFG_MAX_BODY:    cfg_r.max_body    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // room for the byte in decode plus the incoming one, two results each
  assign fifo_need   = {1'b0, fifo_count} + {{(FIFO_CNT_W-1){1'b0}}, in_valid_r, 1'b0};
  assign in_ch.ready = (fifo_need <= (FIFO_CNT_W+1)'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_ch.valid && in_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_byte_r <= in_ch.data_byte;
  end

  cbd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .step_valid (in_valid_r),
    .step_byte  (in_byte_r),
    .res        (res)
  );

  cbd_result_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res),
    .count  (fifo_count),
    .out_ch (out_ch)
  );

endmodule

>>> verif/chunked_body_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// chunked_body_decoder_top_tb: self-checking bench for the body decoder
// One body stream after a single reset: chunked lines with noisy size-line
// tails, fixed-length pass-through stretches, several register settings, and
// one randomly chosen terminating case. Results are predicted on acceptance
// and compared in order against the out channel under random back-pressure.
// ----------------------------------------------------------------------------
module chunked_body_decoder_top_tb;
  import cbd_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 10;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_ITEMS = 190;
  localparam int RUN_LIMIT = 5_000_000;
  localparam int SKIP_BYTES = 2;

  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_FIVE = 8'h35;
  localparam logic [7:0] CH_X    = 8'h78;

  localparam logic [7:0] BLANKS [6] = '{CH_SP, CH_TAB, CH_CR, CH_LF, CH_VT, CH_FF};

  // blanks incl. a lone CR and a lone LF, a ";" extension, data with CR/LF
  localparam logic [7:0] OPENING [23] = '{
    CH_CR, CH_SP, CH_LF, CH_TAB, CH_VT, CH_FF, 8'h30, 8'h33, CH_SEMI, CH_CR, CH_LF,
    8'h00, 8'hFF, CH_CR, 8'h5A, 8'hA5,
    8'h30, 8'h31, CH_CR, CH_LF, CH_LF, CH_CR, CH_LF
  };

  typedef enum int {
    END_ZERO,
    END_NO_DIGIT,
    END_OVERFLOW,
    END_TOO_LARGE,
    END_FIXED,
    END_OVERRUN
  } ending_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  cbd_in_if  in_ch ();
  cbd_out_if out_ch ();

  chunked_body_decoder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // stimulus and scoreboard
  logic [7:0] body_bytes [$];
  result_t    owed_results [$];
  int         err_count;
  int         queued_items;

  // traffic shaping
  int src_idle_pct;
  int snk_idle_pct;
  bit calm;
  bit hold_req;
  bit hold_taken;
  int hold_cnt;
  int src_gap;
  int snk_gap;

  // decoder mirror
  logic [CFG_W-1:0]   fixed_len;
  logic [CFG_W-1:0]   payload_cap;
  phase_t             dec_phase;
  logic [SIZE_W-1:0]  chunk_owed;
  logic [SIZE_W-1:0]  size_val;
  logic               have_digit;
  logic               prev_cr;
  logic [SKIP_W-1:0]  trail_left;
  logic [COUNT_W-1:0] emitted;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic bit blank_byte(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_VT ||
           c == CH_FF;
  endfunction

  function automatic logic [7:0] hex_char(input int nib);
    if (nib < 10) return CH_ZERO + nib[7:0];
    return ($urandom_range(1) ? 8'h41 : 8'h61) + nib[7:0] - 8'd10;
  endfunction

  task automatic owe(input kind_t k, input logic [7:0] b);
    result_t r;
    r.kind = k;
    r.payload = b;
    owed_results.push_back(r);
  endtask

  task automatic fresh_size_line();
    dec_phase = PH_SIZE;
    size_val = '0;
    have_digit = 1'b0;
    prev_cr = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] c);
    int     nib;
    longint acc;
    if (dec_phase >= PH_DONE) return;
    if (fixed_len != 0) begin
      if (emitted >= {1'b0, fixed_len}) begin
        dec_phase = PH_DONE;
        owe(KIND_FINISHED, 8'h00);
        return;
      end
      owe(KIND_PAYLOAD, c);
      emitted = emitted + 1'b1;
      if (emitted == {1'b0, fixed_len}) begin
        dec_phase = PH_DONE;
        owe(KIND_FINISHED, 8'h00);
      end
      return;
    end
    if (dec_phase == PH_DATA) begin
      if ({1'b0, emitted} + 34'd1 > {2'b00, payload_cap}) begin
        dec_phase = PH_DONE;
        owe(KIND_TOOLARGE, 8'h00);
        return;
      end
      owe(KIND_PAYLOAD, c);
      emitted = emitted + 1'b1;
      if (chunk_owed != 0) chunk_owed = chunk_owed - 1'b1;
      if (chunk_owed == 0) begin
        dec_phase = PH_SKIP;
        trail_left = SKIP_W'(SKIP_BYTES);
      end
      return;
    end
    if (dec_phase == PH_SKIP) begin
      if (trail_left != 0) trail_left = trail_left - 1'b1;
      if (trail_left == 0) fresh_size_line();
      return;
    end
    // size line, its tail, or a size line that overflowed
    if (c == CH_LF && prev_cr) begin
      prev_cr = 1'b0;
      if (dec_phase == PH_OVF || !have_digit) begin
        dec_phase = PH_DONE;
        owe(KIND_MALFORMED, 8'h00);
      end else if (size_val == 0) begin
        dec_phase = PH_DONE;
        owe(KIND_FINISHED, 8'h00);
      end else begin
        chunk_owed = size_val;
        dec_phase = PH_DATA;
      end
      return;
    end
    prev_cr = (c == CH_CR);
    if (dec_phase == PH_SIZE) begin
      nib = nibble_of(c);
      if (nib >= 0) begin
        acc = (longint'(size_val) << 4) | longint'(nib);
        if (acc > 64'h7FFF_FFFF) begin
          dec_phase = PH_OVF;
        end else begin
          size_val = acc[SIZE_W-1:0];
          have_digit = 1'b1;
        end
      end else if (have_digit || !blank_byte(c)) begin
        dec_phase = PH_TAIL;
      end
    end
  endtask

  task automatic report_bad(input string what, input result_t want, input logic [1:0] k,
                            input logic [7:0] p);
    if (err_count < MAX_REPORTS)
      $display("mismatch (%s): expected kind %0d payload %02h, got kind %0d payload %02h",
               what, want.kind, want.payload, k, p);
    err_count++;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data_byte <= 8'h00;
      src_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (src_gap != 0) begin
        in_ch.valid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (body_bytes.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(99) < src_idle_pct) begin
        in_ch.valid <= 1'b0;
        src_gap <= $urandom_range(12, 0);
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= body_bytes.pop_front();
      end
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_cnt <= LONG_HOLD;
      hold_taken <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_gap <= 0;
    end else if (hold_cnt != 0) begin
      out_ch.ready <= 1'b0;
    end else if (snk_gap != 0) begin
      out_ch.ready <= 1'b0;
      snk_gap <= snk_gap - 1;
    end else if (!calm && $urandom_range(99) < snk_idle_pct) begin
      out_ch.ready <= 1'b0;
      snk_gap <= $urandom_range(12, 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // predict on each accepted byte, check each accepted result
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (owed_results.size() == 0) begin
          want = '0;
          report_bad("unexpected", want, out_ch.kind, out_ch.payload);
        end else begin
          want = owed_results.pop_front();
          if (out_ch.kind !== want.kind || out_ch.payload !== want.payload)
            report_bad("field", want, out_ch.kind, out_ch.payload);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    body_bytes.push_back(b);
    queued_items++;
  endtask

  task automatic send_hex(input logic [31:0] v);
    int k;
    k = 7;
    while (k > 0 && ((v >> (4 * k)) & 32'hF) == 0) k--;
    for (int i = k; i >= 0; i--) send_byte(hex_char(int'((v >> (4 * i)) & 32'hF)));
  endtask

  task automatic send_crlf();
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // one complete chunk: size line with optional blanks, zeros and tail, data, trailer
  task automatic send_chunk(input int size);
    logic [7:0] b;
    logic [7:0] prev;
    int         n;
    prev = 8'h00;
    n = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
    repeat (n) begin
      b = BLANKS[$urandom_range(5)];
      if (b == CH_LF && prev == CH_CR) b = CH_SP;
      send_byte(b);
      prev = b;
    end
    repeat ($urandom_range(2)) send_byte(CH_ZERO);
    send_hex(size);
    if ($urandom_range(1)) begin
      do b = 8'($urandom_range(255)); while (nibble_of(b) >= 0);
      send_byte(b);
      prev = b;
      repeat ($urandom_range(4)) begin
        b = 8'($urandom_range(255));
        if (b == CH_LF && prev == CH_CR) b = CH_SEMI;
        send_byte(b);
        prev = b;
      end
    end
    send_crlf();
    repeat (size) send_byte(8'($urandom_range(255)));
    repeat (SKIP_BYTES) send_byte(8'($urandom_range(255)));
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BODY_LENGTH) fixed_len = v;
    else payload_cap = v;
    @(negedge clk);
  endtask

  task automatic settle();
    while (body_bytes.size() != 0 || in_ch.valid || owed_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    #RUN_LIMIT;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int      start;
    int      k;
    int      size;
    ending_t ending;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    out_ch.ready = 1'b0;
    err_count = 0;
    queued_items = 0;
    src_idle_pct = 20;
    snk_idle_pct = 20;
    calm = 1'b0;
    hold_req = 1'b0;
    fixed_len = '0;
    payload_cap = MAX_BODY_RST;
    fresh_size_line();
    chunk_owed = '0;
    trail_left = '0;
    emitted = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (OPENING[i]) send_byte(OPENING[i]);
    settle();

    for (int p = 0; p < 8; p++) begin
      src_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 5);
      snk_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 5);
      if (p == 7) calm = 1'b1;
      if (p == 2 || p == 5) begin
        // fixed-length stretch that never reaches its length
        if (p == 2) begin
          write_reg(CFG_BODY_LENGTH, 32'hFFFF_FFFF);
          write_reg(CFG_MAX_BODY, 32'h0000_0000);
        end else begin
          write_reg(CFG_BODY_LENGTH, emitted[31:0] + 32'd1000 + $urandom_range(100000));
          write_reg(CFG_MAX_BODY, $urandom);
        end
        repeat (PHASE_ITEMS) send_byte(8'($urandom_range(255)));
      end else begin
        write_reg(CFG_BODY_LENGTH, 32'h0000_0000);
        case (p)
          1, 6:    write_reg(CFG_MAX_BODY, 32'hFFFF_FFFF);
          3:       write_reg(CFG_MAX_BODY, MAX_BODY_RST);
          default: write_reg(CFG_MAX_BODY, emitted[31:0] + 32'd400 + $urandom_range(5000));
        endcase
        if (p == 3) src_idle_pct = 0;
        start = queued_items;
        while (queued_items - start < PHASE_ITEMS) begin
          size = ($urandom_range(9) == 0) ? $urandom_range(120, 17) : $urandom_range(16, 1);
          send_chunk(size);
        end
        if (p == 3) hold_req = 1'b1;
      end
      settle();
    end

    // exactly one way to end the body
    ending = ending_t'($urandom_range(5));
    case (ending)
      END_ZERO: begin
        send_byte(CH_ZERO);
        if ($urandom_range(1)) begin
          send_byte(CH_ZERO);
          send_byte(CH_SEMI);
          send_byte(CH_X);
        end
        send_crlf();
      end
      END_NO_DIGIT: begin
        if ($urandom_range(1)) begin
          send_byte(CH_SP);
        end else begin
          // a sign before the digits leaves the line without a digit
          send_byte(CH_DASH);
          send_byte(CH_FIVE);
        end
        send_crlf();
      end
      END_OVERFLOW: begin
        if ($urandom_range(1)) begin
          send_hex(32'h8000_0000);
        end else begin
          send_hex(32'h7FFF_FFFF);
          send_byte(hex_char($urandom_range(15)));
        end
        if ($urandom_range(1)) send_byte(CH_SEMI);
        send_crlf();
      end
      END_TOO_LARGE: begin
        k = $urandom_range(20);
        write_reg(CFG_MAX_BODY, emitted[31:0] + k);
        send_hex(32'h7FFF_FFFF);
        send_crlf();
        repeat (k + 4) send_byte(8'($urandom_range(255)));
      end
      END_FIXED: begin
        k = $urandom_range(20, 1);
        write_reg(CFG_BODY_LENGTH, emitted[31:0] + k);
        repeat (k + 4) send_byte(8'($urandom_range(255)));
      end
      default: begin
        // length already passed: the next byte finishes the body
        write_reg(CFG_BODY_LENGTH, 32'h0000_0001);
        repeat (4) send_byte(8'($urandom_range(255)));
      end
    endcase
    // after the end everything is swallowed
    repeat (20) send_byte(8'($urandom_range(255)));
    settle();

    if (owed_results.size() != 0) begin
      $display("%0d expected results never arrived", owed_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
